@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define HTPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define HTPH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/htph_pkg.sv @@
// ----------------------------------------------------------------------------
// htph_pkg
// Types and constants of the hexagon tile hit test pipeline.
// ----------------------------------------------------------------------------
package htph_pkg;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 12;

  localparam logic [CFG_AW-1:0] CFG_COLUMN = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_ROW    = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_SIZE   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_WIDTH  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_HEIGHT = 3'd4;

  localparam int GRID_W = 8;    // column and row
  localparam int DIM_W  = 12;   // size, width, height
  localparam int PT_W   = 22;   // point coordinates, Q.4

  // Internal coordinates carry 5 fraction bits (half of a Q.4 unit is exact).
  localparam int OFS_W  = 24;           // point minus centre
  localparam int COLW_W = GRID_W + DIM_W;
  localparam int ROWP_W = GRID_W + DIM_W + 3;
  localparam int AREA_W = 2 * DIM_W;    // size * width
  localparam int PROD_W = OFS_W + DIM_W + 1;
  localparam int EDGE_W = PROD_W + 1;   // corner-to-point cross product
  localparam int D2_W   = EDGE_W + 1;   // outer edge cross product

  localparam int N_SIDES = 6;

  // Accepting edge to the edge that takes the result
  localparam int RES_LATENCY = 5;

  typedef struct packed {
    logic signed [OFS_W-1:0] cx;
    logic signed [OFS_W-1:0] cy;
    logic [AREA_W-1:0]       area;
    logic [DIM_W-1:0]        w;
    logic [DIM_W-1:0]        s;
  } geom_t;

  typedef struct packed {
    logic                             valid;
    logic [N_SIDES-1:0][EDGE_W-1:0]   e;
  } cross_t;

endpackage

@@ sv/hex_tile_point_hit_test_unit.sv @@
// Throughput: one point per cycle while busy is low; the five-stage datapath
// sets the latency. busy is high for one cycle after each configuration write
// and after reset, while the centre pipeline settles. Synchronous active-low
// reset clears the tile registers to zero and empties the pipeline; results
// cannot be stalled.
// ----------------------------------------------------------------------------
// hex_tile_point_hit_test_unit
// Point in pointy-top hexagon tile test on an odd-row-shifted grid.
// ----------------------------------------------------------------------------
module hex_tile_point_hit_test_unit
  import htph_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [PT_W-1:0] in_point_x,
  input  logic signed [PT_W-1:0] in_point_y,
  output logic                   out_valid,
  output logic                   out_inside_res,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_DW-1:0]      cfg_wdata
);

  geom_t  geom;
  cross_t xs;
  logic   busy_r, busy_nxt;
  logic   acc;

  // Hold off new points for one cycle while the centre is recomputed
  assign busy_nxt = cfg_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;
  assign acc  = start && !busy_r;

  htph_cfg_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .geom      (geom)
  );

  htph_cross u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .px    (in_point_x),
    .py    (in_point_y),
    .geom  (geom),
    .xs    (xs)
  );

  htph_classify u_classify (
    .clk            (clk),
    .rst_n          (rst_n),
    .xs             (xs),
    .area           (geom.area),
    .out_valid      (out_valid),
    .out_inside_res (out_inside_res)
  );

endmodule

@@ sv/htph_cfg_geom.sv @@
// ----------------------------------------------------------------------------
// htph_cfg_geom
// Tile registers and a two-stage pipeline that derives the tile centre.
// ----------------------------------------------------------------------------
module htph_cfg_geom
  import htph_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output geom_t             geom
);

  logic [GRID_W-1:0] col_r, col_nxt;
  logic [GRID_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0]  size_r, size_nxt;
  logic [DIM_W-1:0]  width_r, width_nxt;
  logic [DIM_W-1:0]  height_r, height_nxt;

  logic [COLW_W-1:0]        colw_r, colw_nxt;
  logic signed [ROWP_W-1:0] rowp_r, rowp_nxt;
  logic [AREA_W-1:0]        area_r, area_nxt;
  logic signed [DIM_W+1:0]  pitch;
  geom_t                    geom_r, geom_nxt;

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    size_nxt   = size_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_COLUMN: col_nxt    = cfg_wdata[GRID_W-1:0];
        CFG_ROW:    row_nxt    = cfg_wdata[GRID_W-1:0];
        CFG_SIZE:   size_nxt   = cfg_wdata;
        CFG_WIDTH:  width_nxt  = cfg_wdata;
        CFG_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      size_r   <= '0;
      width_r  <= '0;
      height_r <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      size_r   <= size_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Row pitch is 2*height - size in half units; it may go negative
  assign pitch    = $signed({1'b0, height_r, 1'b0}) - $signed({2'b00, size_r});
  assign colw_nxt = col_r * width_r;
  assign rowp_nxt = $signed({1'b0, row_r}) * pitch;
  assign area_nxt = size_r * width_r;

  always_comb begin
    geom_nxt.cx = OFS_W'({colw_r, 1'b0}) + OFS_W'(width_r)
                + (row_r[0] ? OFS_W'(width_r) : '0);
    geom_nxt.cy   = OFS_W'(rowp_r) + OFS_W'({size_r, 1'b0});
    geom_nxt.area = area_r;
    geom_nxt.w    = width_r;
    geom_nxt.s    = size_r;
  end

  always_ff @(posedge clk) begin
    colw_r <= colw_nxt;
    rowp_r <= rowp_nxt;
    area_r <= area_nxt;
    geom_r <= geom_nxt;
  end

  assign geom = geom_r;

endmodule

@@ sv/htph_cross.sv @@
// ----------------------------------------------------------------------------
// htph_cross
// Four stages: capture, offset from centre, products, corner cross products.
// ----------------------------------------------------------------------------
module htph_cross
  import htph_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   acc,
  input  logic signed [PT_W-1:0] px,
  input  logic signed [PT_W-1:0] py,
  input  geom_t                  geom,
  output cross_t                 xs
);

  logic                     v1_r, v2_r, v3_r;
  logic signed [PT_W-1:0]   px1_r, py1_r;
  logic signed [OFS_W-1:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [PROD_W-1:0] a_r, a_nxt, c_r, c_nxt;
  logic signed [DIM_W:0]    w_s, s_s;
  logic signed [EDGE_W-1:0] a_e, c_e, c2_e;
  cross_t                   xs_r, xs_nxt;

  // Point doubled to match the half-unit centre
  assign dx_nxt = $signed({px1_r[PT_W-1], px1_r, 1'b0}) - geom.cx;
  assign dy_nxt = $signed({py1_r[PT_W-1], py1_r, 1'b0}) - geom.cy;

  assign w_s   = $signed({1'b0, geom.w});
  assign s_s   = $signed({1'b0, geom.s});
  assign a_nxt = dy_r * w_s;
  assign c_nxt = dx_r * s_s;

  // Corners relative to the centre: (0,-2S) (-W,-S) (-W,S) (0,2S) (W,S) (W,-S)
  assign a_e  = EDGE_W'(a_r);
  assign c_e  = EDGE_W'(c_r);
  assign c2_e = $signed({c_r, 1'b0});

  always_comb begin
    xs_nxt.valid = v3_r;
    xs_nxt.e[0]  = c2_e;
    xs_nxt.e[1]  = c_e - a_e;
    xs_nxt.e[2]  = -a_e - c_e;
    xs_nxt.e[3]  = -c2_e;
    xs_nxt.e[4]  = a_e - c_e;
    xs_nxt.e[5]  = a_e + c_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      xs_r.valid <= 1'b0;
    end else begin
      v1_r       <= acc;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      xs_r.valid <= xs_nxt.valid;
    end
    xs_r.e <= xs_nxt.e;
  end

  always_ff @(posedge clk) begin
    px1_r  <= px;
    py1_r  <= py;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    a_r    <= a_nxt;
    c_r    <= c_nxt;
  end

  assign xs = xs_r;

endmodule

@@ sv/htph_classify.sv @@
// ----------------------------------------------------------------------------
// htph_classify
// Sign tests of the six fan triangles and the registered result.
// ----------------------------------------------------------------------------
module htph_classify
  import htph_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cross_t            xs,
  input  logic [AREA_W-1:0] area,
  output logic              out_valid,
  output logic              out_inside_res
);

  logic [N_SIDES-1:0] hit;
  logic               valid_r;
  logic               inside_r, inside_nxt;

  for (genvar k = 0; k < N_SIDES; k++) begin : g_tri
    localparam int N = (k + 1) % N_SIDES;
    logic signed [D2_W-1:0] ek, en, d2;

    assign ek = D2_W'($signed(xs.e[k]));
    assign en = D2_W'($signed(xs.e[N]));
    // Outer edge: e_n - e_k plus the corner cross product, -2*size*width
    assign d2 = en - ek - D2_W'({area, 1'b0});

    assign hit[k] = (ek >= 0 && en <= 0 && d2 >= 0) ||
                    (ek <= 0 && en >= 0 && d2 <= 0);
  end

  // Zero size or width flattens every triangle: report inside
  assign inside_nxt = (area == '0) || (|hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= xs.valid;
    end
  end

  always_ff @(posedge clk) begin
    inside_r <= inside_nxt;
  end

  assign out_valid      = valid_r;
  assign out_inside_res = inside_r;

endmodule

@@ sv/htph_checker.sv @@
// ----------------------------------------------------------------------------
// htph_checker
// Port-level checks of transaction timing, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htph_checker
  import htph_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic signed [PT_W-1:0] in_point_x,
  input logic signed [PT_W-1:0] in_point_y,
  input logic                   out_valid,
  input logic                   out_inside_res,
  input logic                   cfg_we,
  input logic [CFG_AW-1:0]      cfg_addr,
  input logic [CFG_DW-1:0]      cfg_wdata
);

  logic unused_ok;
  assign unused_ok = ^{in_point_x, in_point_y, out_inside_res, cfg_addr, cfg_wdata};

  `HTPH_ASSERT(a_result_follows, start && !busy |-> ##5 out_valid, "accepted point gave no result")
  `HTPH_ASSERT(a_no_spurious, out_valid |-> $past(start && !busy, RES_LATENCY), "result without a point")
  `HTPH_ASSERT(a_cfg_blocks, cfg_we |=> busy, "point taken while centre settles")
  `HTPH_ASSERT_ALWAYS(a_reset_busy, !rst_n |=> busy, "busy low straight after reset")

endmodule

bind hex_tile_point_hit_test_unit htph_checker u_htph_checker (.*);

@@ dv/hex_tile_point_hit_test_unit_tb.sv @@
// ----------------------------------------------------------------------------
// hex_tile_point_hit_test_unit_tb
// Self-checking bench for the hexagon tile hit test. A directed table covers
// the reset tile, boundaries, odd rows, negative row pitch, degenerate and
// full-scale tiles; random phases then reprogramme the tile and stream points
// in bursts. Results are checked against table values or a geometric predictor.
// ----------------------------------------------------------------------------
module hex_tile_point_hit_test_unit_tb;
  import htph_pkg::*;

  localparam int PT_MIN         = -(2 ** (PT_W - 1));
  localparam int PT_MAX         = 2 ** (PT_W - 1) - 1;
  localparam int N_PHASES       = 12;
  localparam int PHASE_POINTS   = 125;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [CFG_DW-1:0] col;
    logic [CFG_DW-1:0] row;
    logic [CFG_DW-1:0] size;
    logic [CFG_DW-1:0] width;
    logic [CFG_DW-1:0] height;
  } tile_cfg_t;

  typedef struct {
    int tile;
    int x;
    int y;
    bit given;
    bit val;
  } probe_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic signed [PT_W-1:0] in_point_x = '0;
  logic signed [PT_W-1:0] in_point_y = '0;
  logic                   out_valid;
  logic                   out_inside_res;
  logic                   cfg_we = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr = '0;
  logic [CFG_DW-1:0]      cfg_wdata = '0;

  // typed expectation riding along with the current transaction
  logic exp_given = 1'b0;
  logic exp_val = 1'b0;

  // bench copy of the tile registers
  logic [GRID_W-1:0] t_col = '0;
  logic [GRID_W-1:0] t_row = '0;
  logic [DIM_W-1:0]  t_size = '0;
  logic [DIM_W-1:0]  t_width = '0;
  logic [DIM_W-1:0]  t_height = '0;

  logic hits_due[$];
  logic due_hit;
  int   mismatches = 0;
  int   quiet = 0;

  // tile 0 is the reset state; the directed probes use it without writing it
  tile_cfg_t tiles [7] = '{
    '{12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
    '{12'h000, 12'h000, 12'd64,  12'd112, 12'd128},
    '{12'hA01, 12'h301, 12'd64,  12'd112, 12'd96},   // odd row, junk upper bits
    '{12'h000, 12'h002, 12'd64,  12'd64,  12'd0},    // negative row pitch
    '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF},
    '{12'h003, 12'h000, 12'd100, 12'd0,   12'd50},   // zero width
    '{12'h005, 12'h007, 12'd0,   12'd80,  12'd200}   // zero size
  };

  probe_row_t probes [25] = '{
    '{0, 0,       0,       1, 1},
    '{0, PT_MIN,  PT_MIN,  1, 1},
    '{0, PT_MAX,  PT_MAX,  1, 1},
    '{0, PT_MIN,  PT_MAX,  1, 1},
    '{1, 56,      64,      1, 1},
    '{1, 56,      0,       1, 1},
    '{1, 56,      -1,      1, 0},
    '{1, 0,       64,      1, 1},
    '{1, -1,      64,      1, 0},
    '{1, 112,     64,      1, 1},
    '{1, 113,     64,      1, 0},
    '{1, 0,       0,       1, 0},
    '{1, PT_MAX,  PT_MAX,  1, 0},
    '{1, PT_MIN,  PT_MIN,  1, 0},
    '{2, 224,     128,     1, 1},
    '{2, 224,     192,     1, 1},
    '{2, 224,     193,     1, 0},
    '{3, 32,      0,       1, 1},
    '{3, 32,      -64,     1, 1},
    '{3, 32,      -65,     1, 0},
    '{4, 1048320, 526207,  0, 0},
    '{4, PT_MAX,  PT_MAX,  0, 0},
    '{5, 1000,    -1000,   1, 1},
    '{5, PT_MIN,  0,       1, 1},
    '{6, 0,       0,       1, 1}
  };

  hex_tile_point_hit_test_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .out_valid      (out_valid),
    .out_inside_res (out_inside_res),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tile centre with 6 fraction bits
  function automatic void tile_centre(output longint ox, output longint oy);
    longint cl, rw, sz, wd, ht;
    cl = longint'(t_col);
    rw = longint'(t_row);
    sz = longint'(t_size);
    wd = longint'(t_width);
    ht = longint'(t_height);
    ox = cl * wd * 4 + wd * 2 + (t_row[0] ? wd * 2 : 0);
    oy = rw * (ht * 4 - sz * 2) + sz * 4;
  endfunction

  function automatic longint cross_z(input longint ax, ay, bx, by);
    return ax * by - ay * bx;
  endfunction

  // boundary counts as covered; a zero-area wedge covers everything
  function automatic logic wedge_covers(input longint ax, ay, bx, by, cx, cy, px, py);
    longint area, d1, d2, d3;
    area = cross_z(bx - ax, by - ay, cx - ax, cy - ay);
    if (area == 0) return 1'b1;
    d1 = cross_z(bx - ax, by - ay, px - ax, py - ay);
    d2 = cross_z(cx - bx, cy - by, px - bx, py - by);
    d3 = cross_z(ax - cx, ay - cy, px - cx, py - cy);
    if (d1 >= 0 && d2 >= 0 && d3 >= 0) return 1'b1;
    if (d1 <= 0 && d2 <= 0 && d3 <= 0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic point_in_tile(input logic signed [PT_W-1:0] qx, qy);
    longint ox, oy, hw, hs, qs, px, py;
    longint vx [N_SIDES];
    longint vy [N_SIDES];
    logic   hit;
    tile_centre(ox, oy);
    hw = longint'(t_width) * 2;
    hs = longint'(t_size) * 4;
    qs = longint'(t_size) * 2;
    px = longint'(qx) * 4;
    py = longint'(qy) * 4;
    vx = '{ox, ox - hw, ox - hw, ox, ox + hw, ox + hw};
    vy = '{oy - hs, oy - qs, oy + qs, oy + hs, oy + qs, oy - qs};
    hit = 1'b0;
    for (int k = 0; k < N_SIDES; k++) begin
      if (wedge_covers(ox, oy, vx[k], vy[k], vx[(k + 1) % N_SIDES], vy[(k + 1) % N_SIDES],
                       px, py)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // mostly near the tile or on its corners, the rest anywhere
  function automatic void pick_point(output longint x, output longint y);
    longint ox, oy, hw, hs, jx, jy;
    longint dx [N_SIDES];
    longint dy [N_SIDES];
    int     k;
    tile_centre(ox, oy);
    ox = ox >>> 2;
    oy = oy >>> 2;
    hw = longint'(t_width) / 2;
    hs = longint'(t_size);
    dx = '{0, -hw, -hw, 0, hw, hw};
    dy = '{-hs, -hs / 2, hs / 2, hs, hs / 2, -hs / 2};
    case ($urandom_range(0, 9))
      0, 1: begin
        x = longint'($urandom);
        y = longint'($urandom);
      end
      2, 3: begin
        k = $urandom_range(0, N_SIDES - 1);
        jx = longint'($urandom_range(0, 2));
        jy = longint'($urandom_range(0, 2));
        x = ox + dx[k] + jx - 1;
        y = oy + dy[k] + jy - 1;
      end
      default: begin
        jx = longint'($urandom_range(0, 32'(2 * hw + 16)));
        jy = longint'($urandom_range(0, 32'(2 * hs + 16)));
        x = ox + jx - hw - 8;
        y = oy + jy - hs - 8;
      end
    endcase
  endfunction

  function automatic tile_cfg_t random_tile();
    tile_cfg_t t;
    t.col = CFG_DW'($urandom);
    t.row = CFG_DW'($urandom);
    t.size = CFG_DW'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 96));
    t.width = CFG_DW'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 96));
    t.height = CFG_DW'(($urandom_range(0, 1) == 0) ? $urandom_range(0, t.size) : $urandom);
    return t;
  endfunction

  task automatic cfg_write(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_COLUMN: t_col = val[GRID_W-1:0];
      CFG_ROW:    t_row = val[GRID_W-1:0];
      CFG_SIZE:   t_size = val[DIM_W-1:0];
      CFG_WIDTH:  t_width = val[DIM_W-1:0];
      CFG_HEIGHT: t_height = val[DIM_W-1:0];
      default: ;
    endcase
  endtask

  // programme a tile, then poke the unused indexes, which must change nothing
  task automatic set_tile(input tile_cfg_t t);
    cfg_write(CFG_COLUMN, t.col);
    cfg_write(CFG_ROW, t.row);
    cfg_write(CFG_SIZE, t.size);
    cfg_write(CFG_WIDTH, t.width);
    cfg_write(CFG_HEIGHT, t.height);
    for (int a = CFG_HEIGHT + 1; a < 2 ** CFG_AW; a++) begin
      cfg_write(CFG_AW'(a), CFG_DW'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_point(input longint x, input longint y, input bit given, input bit val);
    start <= 1'b1;
    in_point_x <= x[PT_W-1:0];
    in_point_y <= y[PT_W-1:0];
    exp_given <= given;
    exp_val <= val;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every outstanding result is back and the pipe is empty
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (hits_due.size() != 0) @(posedge clk);
    repeat (RES_LATENCY) @(posedge clk);
  endtask

  // check results first, then log the transaction accepted on this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (hits_due.size() == 0) begin
          $error("out_inside_res: expected none, actual %0b", out_inside_res);
          mismatches++;
        end else begin
          due_hit = hits_due.pop_front();
          if (out_inside_res !== due_hit) begin
            $error("out_inside_res: expected %0b, actual %0b", due_hit, out_inside_res);
            mismatches++;
          end
        end
      end
      if (start && busy === 1'b0) begin
        hits_due.push_back(exp_given ? exp_val : point_in_tile(in_point_x, in_point_y));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("hex_tile_point_hit_test_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    int        cur_tile;
    int        sent;
    int        burst;
    bit        steady;
    longint    px, py;
    tile_cfg_t t;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    cur_tile = 0;
    foreach (probes[i]) begin
      if (probes[i].tile != cur_tile) begin
        drain_results();
        set_tile(tiles[probes[i].tile]);
        cur_tile = probes[i].tile;
      end
      send_point(probes[i].x, probes[i].y, probes[i].given, probes[i].val);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: t = tiles[0];
        1: t = tiles[4];
        2: t = '{12'h000, 12'h0FF, 12'hFFF, 12'h001, 12'h000};
        default: t = random_tile();
      endcase
      set_tile(t);
      steady = (ph % 4 == 2);
      sent = 0;
      while (sent < PHASE_POINTS) begin
        burst = $urandom_range(1, 24);
        for (int i = 0; i < burst && sent < PHASE_POINTS; i++) begin
          pick_point(px, py);
          send_point(px, py, 1'b0, 1'b0);
          sent++;
        end
        if ($urandom_range(0, 9) == 0) begin
          drain_results();
        end else if (!steady) begin
          burst = $urandom_range(0, 8);
          if (burst > 0) pause_sender(burst);
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("hex_tile_point_hit_test_unit test passed");
    end else begin
      $display("hex_tile_point_hit_test_unit test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/htph_pkg.sv
sv/htph_cfg_geom.sv
sv/htph_cross.sv
sv/htph_classify.sv
sv/hex_tile_point_hit_test_unit.sv
sv/htph_checker.sv
dv/hex_tile_point_hit_test_unit_tb.sv
